@@ rtl/dd_pkg.sv @@
// Shared types, constants and calendar helper functions for the date difference block.
// No dependencies; every other file in rtl imports this package.
package dd_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int DaysW  = 22;
	// Day numbers reach about 365.25 * 2^14, which needs one bit more than the output.
	localparam int CountW = 23;

	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	localparam logic [DaysW-1:0] DaysSat = {DaysW{1'b1}};

	typedef struct packed {
		logic [DayW-1:0]   day_one;
		logic [MonthW-1:0] month_one;
		logic [YearW-1:0]  year_one;
		logic [DayW-1:0]   day_two;
		logic [MonthW-1:0] month_two;
		logic [YearW-1:0]  year_two;
	} dd_req_t;

	typedef struct packed {
		logic [DaysW-1:0] days_between;
		logic             first_valid;
		logic             second_valid;
	} dd_res_t;

	// Floor division by 100 for values below 2^15: multiply by 5243 / 2^19.
	// The reciprocal error stays below one hundredth over that range, so it is exact.
	function automatic logic [8:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'd5243;
		return p[27:19];
	endfunction

	// Gregorian leap year: divisible by 4, and not by 100 unless by 400.
	// A multiple of 100 is a multiple of 400 exactly when its quotient by 100 is a multiple of 4.
	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [8:0]       q;
		logic [YearW-1:0] prod;
		logic [YearW-1:0] r;
		q    = div100({1'b0, y});
		prod = 14'(q) * 14'd100;
		r    = y - prod;
		return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/date_difference_days_top.sv @@
// Top level of the Gregorian day difference block: input register, day count stage, result stage.
// Depends on dd_pkg, dd_date_check and dd_day_count.
//
// Usage:
// A date pair is presented on req and transferred at a rising edge where start is high and
// busy is low. busy is always low, so a new pair can be transferred in every cycle.
// Each transfer produces exactly one result on the result port, marked by done for one
// clock cycle. The result passes through the stages in order: the pair is registered,
// both dates are checked and turned into day numbers, then the absolute difference is
// formed, saturated to the output width and forced to zero when either date is invalid.
// Throughput is one pair per cycle; the day number stage, with its constant multiply and
// reciprocal divisions by 100, sets the clock rate.
// Results are ordered as the pairs were transferred. The receiver cannot stall, so the
// result must be taken in the cycle that done is high.
// Reset clears the stage valid flags; no result appears until a new pair is transferred.
// MAX_YEAR is the largest accepted year.
module date_difference_days_top import dd_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dd_req_t req,
	output logic    done,
	output dd_res_t result
);

	dd_req_t           req_s1;
	logic              vld_s1;
	logic              v1_c;
	logic              v2_c;
	logic [CountW-1:0] a_c;
	logic [CountW-1:0] b_c;
	logic [CountW-1:0] a_s2;
	logic [CountW-1:0] b_s2;
	logic              v1_s2;
	logic              v2_s2;
	logic              vld_s2;
	logic [CountW-1:0] diff_c;
	dd_res_t           res_c;
	dd_res_t           result_q;
	logic              done_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	dd_date_check #(.MAX_YEAR(MAX_YEAR)) u_check_one (
		.day   (req_s1.day_one),
		.month (req_s1.month_one),
		.year  (req_s1.year_one),
		.valid (v1_c)
	);

	dd_date_check #(.MAX_YEAR(MAX_YEAR)) u_check_two (
		.day   (req_s1.day_two),
		.month (req_s1.month_two),
		.year  (req_s1.year_two),
		.valid (v2_c)
	);

	dd_day_count u_count_one (
		.day   (req_s1.day_one),
		.month (req_s1.month_one),
		.year  (req_s1.year_one),
		.count (a_c)
	);

	dd_day_count u_count_two (
		.day   (req_s1.day_two),
		.month (req_s1.month_two),
		.year  (req_s1.year_two),
		.count (b_c)
	);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			a_s2  <= a_c;
			b_s2  <= b_c;
			v1_s2 <= v1_c;
			v2_s2 <= v2_c;
		end
	end

	always_comb begin
		diff_c = (a_s2 > b_s2) ? (a_s2 - b_s2) : (b_s2 - a_s2);
		res_c.first_valid  = v1_s2;
		res_c.second_valid = v2_s2;
		if (!(v1_s2 && v2_s2)) begin
			res_c.days_between = '0;
		end else if (diff_c[CountW-1]) begin
			res_c.days_between = DaysSat;
		end else begin
			res_c.days_between = diff_c[DaysW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			result_q <= res_c;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/dd_date_check.sv @@
// Validity check of one calendar date: year limit, month range and day within the month.
// Depends on dd_pkg for widths and the leap year and month length helpers.
module dd_date_check import dd_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic [DayW-1:0]   day,
	input  logic [MonthW-1:0] month,
	input  logic [YearW-1:0]  year,
	output logic              valid
);

	localparam logic [16:0] MaxYear = 17'(MAX_YEAR);

	logic [4:0] len;
	logic       year_ok;
	logic       month_ok;

	assign year_ok  = (17'(year) <= MaxYear);
	assign month_ok = (month >= MonthJan) && (month <= MonthDec);
	assign len      = month_len(month, is_leap(year));
	assign valid    = year_ok && month_ok && (day != '0) && (day <= len);

endmodule

@@ rtl/dd_day_count.sv @@
// Closed-form day number of a date, counted from 1 January of year 0.
// Depends on dd_pkg; the result is meaningful only for a valid date.
module dd_day_count import dd_pkg::*; (
	input  logic [DayW-1:0]   day,
	input  logic [MonthW-1:0] month,
	input  logic [YearW-1:0]  year,
	output logic [CountW-1:0] count
);

	logic [14:0]       y15;
	logic [14:0]       sum399;
	logic [12:0]       t4;
	logic [8:0]        t100;
	logic [8:0]        t400;
	logic [CountW-1:0] base;
	logic              leap_adj;

	assign y15    = {1'b0, year};
	assign sum399 = y15 + 15'd399;
	// Leap days in the years before this one, as ceiling quotients.
	assign t4     = 13'((y15 + 15'd3) >> 2);
	assign t100   = div100(y15 + 15'd99);
	// Floor of x / 400 is the floor of (x / 4) / 100.
	assign t400   = div100(15'(sum399 >> 2));

	assign base     = 23'(year) * 23'd365 + 23'(t4) - 23'(t100) + 23'(t400);
	assign leap_adj = (month > MonthFeb) && is_leap(year);
	assign count    = base + 23'(days_before(month)) + 23'(leap_adj) + 23'(day);

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for date_difference_days_top: date pairs go in, day differences out.
// Depends on dd_pkg and the RTL of the block; expected results come from a calendar predictor.
`timescale 1ns / 100ps

module tb_top import dd_pkg::*; ();

	localparam int YEAR_LIMIT     = 9999;
	localparam int RANDOM_PAIRS   = 500;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int DRAIN_CYCLES   = 8;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	dd_req_t req;
	logic    done;
	dd_res_t result;

	dd_res_t pending_results[$];
	int      mismatch_count;
	int      idle_cycles;
	bit      no_idle;

	date_difference_days_top #(
		.MAX_YEAR(YEAR_LIMIT)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Calendar predictor.

	function automatic bit calendar_leap(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in_month(input int m, input int y);
		int len;
		case (m)
			4, 6, 9, 11: len = 30;
			int'(MonthFeb): len = calendar_leap(y) ? 29 : 28;
			1, 3, 5, 7, 8, 10, 12: len = 31;
			default: len = 0;
		endcase
		return len;
	endfunction

	function automatic bit date_exists(input int d, input int m, input int y);
		if (y > YEAR_LIMIT || m < 1 || m > 12)
			return 1'b0;
		return (d >= 1) && (d <= days_in_month(m, y));
	endfunction

	// Days since the start of year 0, where year 0 itself counts as a leap year.
	function automatic longint ordinal_day(input int d, input int m, input int y);
		longint n;
		n = 365 * longint'(y) + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int k = 1; k < m; k++)
			n += days_in_month(k, y);
		return n + d;
	endfunction

	function automatic dd_res_t expected_difference(input dd_req_t p);
		dd_res_t r;
		longint  a;
		longint  b;
		longint  diff;
		r.first_valid  = date_exists(p.day_one, p.month_one, p.year_one);
		r.second_valid = date_exists(p.day_two, p.month_two, p.year_two);
		diff = 0;
		if (r.first_valid && r.second_valid) begin
			a    = ordinal_day(p.day_one, p.month_one, p.year_one);
			b    = ordinal_day(p.day_two, p.month_two, p.year_two);
			diff = (a > b) ? a - b : b - a;
			if (diff > longint'(DaysSat))
				diff = longint'(DaysSat);
		end
		r.days_between = DaysW'(diff);
		return r;
	endfunction

	function automatic dd_req_t make_pair(input int d1, input int m1, input int y1,
	                                      input int d2, input int m2, input int y2);
		dd_req_t p;
		p.day_one   = DayW'(d1);
		p.month_one = MonthW'(m1);
		p.year_one  = YearW'(y1);
		p.day_two   = DayW'(d2);
		p.month_two = MonthW'(m2);
		p.year_two  = YearW'(y2);
		return p;
	endfunction

	function automatic void pick_valid_date(output int d, output int m, output int y);
		int len;
		case ($urandom_range(0, 3))
			0: y = $urandom_range(0, YEAR_LIMIT);
			1: y = $urandom_range(0, YEAR_LIMIT / 100) * 100;
			2: y = $urandom_range(0, 12);
			default: y = $urandom_range(YEAR_LIMIT - 14, YEAR_LIMIT);
		endcase
		m   = $urandom_range(1, 12);
		len = days_in_month(m, y);
		case ($urandom_range(0, 3))
			0: d = 1;
			1: d = len;
			default: d = $urandom_range(1, len);
		endcase
	endfunction

	// Spoils one field of a valid date so that the date no longer exists.
	function automatic void break_date(inout int d, inout int m, inout int y);
		int len;
		case ($urandom_range(0, 3))
			0: d = 0;
			1: m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
			2: y = $urandom_range(YEAR_LIMIT + 1, (1 << YearW) - 1);
			default: begin
				len = days_in_month(m, y);
				if (len == 31)
					d = 0;
				else
					d = $urandom_range(len + 1, 31);
			end
		endcase
	endfunction

	// Sends one date pair and returns just after the edge at which it was transferred.
	task automatic send_pair(input dd_req_t pair);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= pair;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	// Expectations are queued at the transfer edge and results are checked in the same process.
	always @(posedge clk) begin
		dd_res_t want;
		if (arst_n) begin
			if (start && busy === 1'b0)
				pending_results.push_back(expected_difference(req));
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result with no transfer pending: days_between %0d",
					       result.days_between);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (result.days_between !== want.days_between) begin
						$error("days_between: expected %0d, got %0d",
						       want.days_between, result.days_between);
						mismatch_count++;
					end
					if (result.first_valid !== want.first_valid) begin
						$error("first_valid: expected %0b, got %0b",
						       want.first_valid, result.first_valid);
						mismatch_count++;
					end
					if (result.second_valid !== want.second_valid) begin
						$error("second_valid: expected %0b, got %0b",
						       want.second_valid, result.second_valid);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && busy === 1'b0) || done === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic test_extremes();
		send_pair(make_pair(1, 1, 0, 1, 1, 0));
		send_pair(make_pair(1, 1, 0, 31, 12, YEAR_LIMIT));
		send_pair(make_pair(31, 12, YEAR_LIMIT, 31, 12, YEAR_LIMIT));
		send_pair(make_pair(15, 6, 2023, 16, 6, 2023));
	endtask

	task automatic test_first_later();
		send_pair(make_pair(31, 12, YEAR_LIMIT, 1, 1, 0));
		send_pair(make_pair(1, 3, 2000, 28, 2, 2000));
		send_pair(make_pair(1, 1, 2024, 31, 12, 2023));
	endtask

	task automatic test_invalid_fields();
		send_pair(make_pair(0, 5, 1999, 10, 5, 1999));
		send_pair(make_pair(10, 5, 1999, 0, 5, 1999));
		send_pair(make_pair(1, 0, 1999, 1, 13, 1999));
		send_pair(make_pair(1, 15, 1999, 1, 1, 1999));
		send_pair(make_pair(1, 1, YEAR_LIMIT + 1, 1, 1, (1 << YearW) - 1));
		send_pair(make_pair(31, 4, 2010, 31, 15, (1 << YearW) - 1));
		send_pair(make_pair(30, 2, 2000, 5, 5, 5));
	endtask

	task automatic test_leap_years();
		send_pair(make_pair(29, 2, 2000, 1, 1, 2000));
		send_pair(make_pair(29, 2, 1900, 1, 1, 1900));
		send_pair(make_pair(29, 2, 2004, 29, 2, 2008));
		send_pair(make_pair(29, 2, 2001, 28, 2, 2001));
		send_pair(make_pair(29, 2, 0, 1, 3, 0));
		send_pair(make_pair(28, 2, 1900, 1, 3, 1900));
		send_pair(make_pair(31, 12, 0, 1, 1, 1));
	endtask

	task automatic test_random_pairs();
		int d1, m1, y1, d2, m2, y2;
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			// Every 50 pairs, choose at random between a chunk with random gaps and a back-to-back chunk.
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			pick_valid_date(d1, m1, y1);
			pick_valid_date(d2, m2, y2);
			if ($urandom_range(0, 3) == 0)
				y2 = y1;
			case ($urandom_range(0, 9))
				6, 7: begin
					if ($urandom_range(0, 1) == 0)
						break_date(d1, m1, y1);
					if ($urandom_range(0, 1) == 0)
						break_date(d2, m2, y2);
					else if ($urandom_range(0, 1) == 0)
						break_date(d1, m1, y1);
				end
				8, 9: begin
					d1 = $urandom_range(0, 31);
					m1 = $urandom_range(0, 15);
					y1 = $urandom_range(0, (1 << YearW) - 1);
					d2 = $urandom_range(0, 31);
					m2 = $urandom_range(0, 15);
					y2 = $urandom_range(0, (1 << YearW) - 1);
				end
				default: ;
			endcase
			send_pair(make_pair(d1, m1, y1, d2, m2, y2));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		mismatch_count = 0;
		no_idle        = 1'b0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_first_later();
		test_invalid_fields();
		test_leap_years();
		test_random_pairs();
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
